[rtl/lcdwm_pkg.sv]
// lcdwm_pkg: shared types and constants for the latency compensated dry/wet mixer
// register map, field widths and reset values of the configuration registers
// no dependencies
package lcdwm_pkg;

	localparam int CH_W   = 3;
	localparam int LAT_W  = 10;
	localparam int MIXT_W = 17;
	localparam int RLEN_W = 16;
	localparam int NCH_W  = 4;
	localparam int GAIN_W = 17;
	localparam int MIX_W  = 33;
	localparam int STEP_W = 34;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam int DIV_STEPS = MIX_W;
	localparam int DIV_CW    = 6;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_LATENCY      = 2'd0;
	localparam reg_idx_t REG_MIX_TARGET   = 2'd1;
	localparam reg_idx_t REG_RAMP_LENGTH  = 2'd2;
	localparam reg_idx_t REG_NUM_CHANNELS = 2'd3;

	localparam logic [MIXT_W-1:0] FULL_MIX        = 17'd65536;
	localparam logic [RLEN_W-1:0] RST_RAMP_LENGTH = 16'd960;
	localparam logic [NCH_W-1:0]  RST_NUM_CH      = 4'd2;

endpackage

[rtl/latency_compensated_dry_wet_mixer_top.sv]
// latency_compensated_dry_wet_mixer_top: dry/wet crossfade with dry-path delay ring
// and a linear gain ramp, apb configuration, three-stage mixing pipeline
// depends on lcdwm_pkg
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------
//  input     | in  | in_valid / in_ready    | channel, dry_sample, wet_sample
//  result    | out | out_valid / out_ready  | mixed_sample
//  config    | in  | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// one beat per cycle sustained while in_ready is high; a result passes through the ring
// read, the two multipliers and the round and saturate step, one register each
// after reset a clearing pass zeroes all CHANNELS*MAX_DELAY ring entries (8192 by
// default), with in_ready low; apb writes are taken during the pass
// a mix_target write that starts a ramp runs a bit-serial divider with in_ready low;
// with MAX_DELAY below 1024 a latency write folds the value modulo MAX_DELAY by one
// subtraction a cycle, also with in_ready low
// output stall: the three stages fill, then in_ready drops
module latency_compensated_dry_wet_mixer_top #(
	parameter int MAX_DELAY   = 1024,
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input beats
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [lcdwm_pkg::CH_W-1:0]           channel,
	input  logic signed [SAMPLE_BITS-1:0]        dry_sample,
	input  logic signed [SAMPLE_BITS-1:0]        wet_sample,
	// result beats
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        mixed_sample,
	// apb
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lcdwm_pkg::APB_AW-1:0]         paddr,
	input  logic [lcdwm_pkg::APB_DW-1:0]         pwdata,
	output logic [lcdwm_pkg::APB_DW-1:0]         prdata,
	output logic                                 pready
);
	import lcdwm_pkg::*;

	localparam int S      = SAMPLE_BITS;
	localparam int WP_W   = $clog2(MAX_DELAY);
	localparam int MEM_D  = CHANNELS * MAX_DELAY;
	localparam int MEM_AW = $clog2(MEM_D);
	localparam int AW_R   = ((WP_W > LAT_W) ? WP_W : LAT_W) + 1;
	localparam int PW     = S + 18;
	localparam int SW     = S + 19;

	localparam logic [31:0]       MAXD32   = MAX_DELAY;
	localparam logic [MEM_AW-1:0] MAXD_A   = MEM_AW'(MAX_DELAY);
	localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_D - 1);
	localparam logic [WP_W-1:0]   WP_LAST  = WP_W'(MAX_DELAY - 1);
	localparam logic [AW_R-1:0]   MAXD_R   = AW_R'(MAX_DELAY);
	localparam logic [NCH_W-1:0]  CH_MAX   = NCH_W'(CHANNELS);
	localparam logic [31:0]       CH32     = CHANNELS;
	localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);
	localparam logic [MIX_W-1:0]  MIX_FULL = {FULL_MIX, 16'd0};

	localparam logic signed [S+2:0] SAT_HI = {4'b0000, {(S-1){1'b1}}};
	localparam logic signed [S+2:0] SAT_LO = {4'b1111, {(S-1){1'b0}}};

	// configuration registers
	logic [LAT_W-1:0]  latency_q;
	logic [LAT_W-1:0]  lat_red_q;      // latency modulo MAX_DELAY
	logic [MIXT_W-1:0] mix_target_q;
	logic [RLEN_W-1:0] ramp_len_q;
	logic [NCH_W-1:0]  num_ch_q;

	// mixer state
	logic [MIX_W-1:0]         cur_mix_q;
	logic signed [STEP_W-1:0] ramp_step_q;
	logic [RLEN_W-1:0]        ramp_rem_q;
	logic [WP_W-1:0]          wp_q;

	// ramp step divider
	logic              div_busy_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic              div_neg_q;
	logic [MIX_W-1:0]  div_quo_q;
	logic [RLEN_W-1:0] div_rem_q;

	// ring clearing pass
	logic              clr_busy_q;
	logic [MEM_AW-1:0] clr_addr_q;

	// ring store
	logic [S-1:0] ring_mem [MEM_D];

	// pipeline
	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [S-1:0]  wet_s1, dry_now_s1, rd_data_s1;
	logic                 byp_s1;
	logic [GAIN_W-1:0]    gain_s1;
	logic signed [PW-1:0] prod_wet_s2, prod_dry_s2;
	logic signed [S-1:0]  mixed_s3;

	// combinational
	logic                 ld1, ld2, ld3, accept, lat_busy, cfg_wr, last_ch;
	logic [CH_W-1:0]      ring_ch;
	logic [NCH_W-1:0]     ch_count;
	logic [AW_R-1:0]      wp_x, lat_x, rd_x;
	logic [WP_W-1:0]      rd_pos;
	logic [MEM_AW-1:0]    wr_addr, rd_addr, mem_wa;
	logic [S-1:0]         mem_wd;
	logic                 mem_we;
	logic signed [STEP_W:0] mix_sum, mix_raw;
	logic [MIX_W-1:0]     mix_c;
	logic [MIX_W:0]       gain_rnd;
	logic [GAIN_W-1:0]    gain;
	logic [RLEN_W:0]      div_trial;
	logic                 div_ge;
	logic [RLEN_W:0]      div_rem_nx;
	logic [MIX_W-1:0]     div_quo_nx;
	logic [MIXT_W-1:0]    tgt_w;
	logic signed [STEP_W-1:0] tgt_diff;
	logic [STEP_W-1:0]    tgt_mag;
	logic signed [S-1:0]  dry_s1;
	logic signed [17:0]   gw_sx, gd_sx;
	logic signed [SW-1:0] acc;
	logic signed [S+2:0]  acc_sh;

	// handshake: each stage loads when it is empty or the next one moves
	assign ld3      = !valid_s3 || out_ready;
	assign ld2      = !valid_s2 || ld3;
	assign ld1      = !valid_s1 || ld2;
	assign lat_busy = 32'(lat_red_q) >= MAXD32;
	assign in_ready = ld1 && !clr_busy_q && !div_busy_q && !lat_busy;
	assign accept   = in_valid && in_ready;
	assign out_valid    = valid_s3;
	assign mixed_sample = mixed_s3;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// readback
	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_LATENCY:      prdata = APB_DW'(latency_q);
			REG_MIX_TARGET:   prdata = APB_DW'(mix_target_q);
			REG_RAMP_LENGTH:  prdata = APB_DW'(ramp_len_q);
			REG_NUM_CHANNELS: prdata = APB_DW'(num_ch_q);
			default:          prdata = '0;
		endcase
	end

	// ring addressing and frame bookkeeping
	always_comb begin
		ring_ch = channel;
		for (int k = 0; k < 8; k++) begin
			if (32'(ring_ch) >= CH32) begin
				ring_ch = ring_ch - CH_W'(CHANNELS);
			end
		end
		if (num_ch_q == '0) begin
			ch_count = NCH_W'(1);
		end else if (num_ch_q > CH_MAX) begin
			ch_count = CH_MAX;
		end else begin
			ch_count = num_ch_q;
		end
		last_ch = {1'b0, channel} == (ch_count - NCH_W'(1));

		wp_x  = AW_R'(wp_q);
		lat_x = AW_R'(lat_red_q);
		if (wp_x >= lat_x) begin
			rd_x = wp_x - lat_x;
		end else begin
			rd_x = wp_x + MAXD_R - lat_x;
		end
		rd_pos  = rd_x[WP_W-1:0];
		wr_addr = MEM_AW'(ring_ch) * MAXD_A + MEM_AW'(wp_q);
		rd_addr = MEM_AW'(ring_ch) * MAXD_A + MEM_AW'(rd_pos);

		mem_we = clr_busy_q || accept;
		mem_wa = clr_busy_q ? clr_addr_q : wr_addr;
		mem_wd = clr_busy_q ? '0 : dry_sample;
	end

	// gain for this beat: ramp step, exact landing on the last ramp frame, or hold
	always_comb begin
		mix_sum = signed'({2'b00, cur_mix_q}) + STEP_W'(0) + (STEP_W+1)'(ramp_step_q);
		if (ramp_rem_q > RLEN_W'(1)) begin
			mix_raw = mix_sum;
		end else if (ramp_rem_q == RLEN_W'(1)) begin
			mix_raw = signed'({2'b00, mix_target_q, 16'd0});
		end else begin
			mix_raw = signed'({2'b00, cur_mix_q});
		end
		if (mix_raw < 0) begin
			mix_c = '0;
		end else if (mix_raw > signed'({2'b00, MIX_FULL})) begin
			mix_c = MIX_FULL;
		end else begin
			mix_c = mix_raw[MIX_W-1:0];
		end
		gain_rnd = {1'b0, mix_c} + (MIX_W+1)'(32768);
		gain     = gain_rnd[16 +: GAIN_W];
	end

	// divider step and ramp start values
	always_comb begin
		div_trial  = {div_rem_q, div_quo_q[MIX_W-1]};
		div_ge     = div_trial >= {1'b0, ramp_len_q};
		div_rem_nx = div_ge ? div_trial - {1'b0, ramp_len_q} : div_trial;
		div_quo_nx = {div_quo_q[MIX_W-2:0], div_ge};

		tgt_w    = (pwdata[MIXT_W-1:0] > FULL_MIX) ? FULL_MIX : pwdata[MIXT_W-1:0];
		tgt_diff = signed'({1'b0, tgt_w, 16'd0}) - signed'({1'b0, cur_mix_q});
		tgt_mag  = tgt_diff[STEP_W-1] ? STEP_W'(-tgt_diff) : STEP_W'(tgt_diff);
	end

	// configuration, ramp and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q    <= '0;
			lat_red_q    <= '0;
			mix_target_q <= FULL_MIX;
			ramp_len_q   <= RST_RAMP_LENGTH;
			num_ch_q     <= RST_NUM_CH;
			cur_mix_q    <= MIX_FULL;
			ramp_step_q  <= '0;
			ramp_rem_q   <= '0;
			wp_q         <= '0;
			div_busy_q   <= 1'b0;
			div_cnt_q    <= '0;
			div_neg_q    <= 1'b0;
			div_quo_q    <= '0;
			div_rem_q    <= '0;
		end else begin
			if (lat_busy) begin
				lat_red_q <= lat_red_q - MAXD32[LAT_W-1:0];
			end
			if (div_busy_q) begin
				div_quo_q <= div_quo_nx;
				div_rem_q <= div_rem_nx[RLEN_W-1:0];
				div_cnt_q <= div_cnt_q + DIV_CW'(1);
				if (div_cnt_q == DIV_LAST) begin
					div_busy_q  <= 1'b0;
					ramp_step_q <= div_neg_q ? -signed'({1'b0, div_quo_nx})
						: signed'({1'b0, div_quo_nx});
				end
			end
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_LATENCY: begin
						latency_q <= pwdata[LAT_W-1:0];
						lat_red_q <= pwdata[LAT_W-1:0];
					end
					REG_MIX_TARGET: begin
						if (tgt_w != mix_target_q) begin
							mix_target_q <= tgt_w;
							if (ramp_len_q == '0) begin
								cur_mix_q   <= {tgt_w, 16'd0};
								ramp_step_q <= '0;
								ramp_rem_q  <= '0;
								div_busy_q  <= 1'b0;
							end else begin
								div_busy_q <= 1'b1;
								div_cnt_q  <= '0;
								div_neg_q  <= tgt_diff[STEP_W-1];
								div_quo_q  <= tgt_mag[MIX_W-1:0];
								div_rem_q  <= '0;
								ramp_rem_q <= ramp_len_q;
							end
						end
					end
					REG_RAMP_LENGTH: begin
						// snap to the target, ending any ramp
						ramp_len_q  <= pwdata[RLEN_W-1:0];
						cur_mix_q   <= {mix_target_q, 16'd0};
						ramp_step_q <= '0;
						ramp_rem_q  <= '0;
						div_busy_q  <= 1'b0;
					end
					REG_NUM_CHANNELS: begin
						num_ch_q <= pwdata[NCH_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (accept && last_ch) begin
				// frame boundary: commit the gain, count the ramp, move the ring
				cur_mix_q <= mix_c;
				if (ramp_rem_q != '0) begin
					ramp_rem_q <= ramp_rem_q - RLEN_W'(1);
					if (ramp_rem_q == RLEN_W'(1)) begin
						ramp_step_q <= '0;
					end
				end
				wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + WP_W'(1);
			end
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + MEM_AW'(1);
			if (clr_addr_q == MEM_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ring: write port for the new dry beat, registered read of the delayed one
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rd_data_s1 <= ring_mem[rd_addr];
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				valid_s1 <= accept;
			end
			if (ld2) begin
				valid_s2 <= valid_s1;
			end
			if (ld3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage 2 and 3 arithmetic
	always_comb begin
		// zero latency reads the beat just written
		dry_s1 = byp_s1 ? dry_now_s1 : rd_data_s1;
		gw_sx  = signed'({1'b0, gain_s1});
		gd_sx  = signed'({1'b0, FULL_MIX - gain_s1});
		acc    = SW'(prod_wet_s2) + SW'(prod_dry_s2) + SW'(32768);
		acc_sh = acc[SW-1:16];
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			wet_s1     <= wet_sample;
			dry_now_s1 <= dry_sample;
			byp_s1     <= lat_red_q == '0;
			gain_s1    <= gain;
		end
		if (ld2 && valid_s1) begin
			prod_wet_s2 <= PW'(wet_s1) * PW'(gw_sx);
			prod_dry_s2 <= PW'(dry_s1) * PW'(gd_sx);
		end
		if (ld3 && valid_s2) begin
			if (acc_sh > SAT_HI) begin
				mixed_s3 <= SAT_HI[S-1:0];
			end else if (acc_sh < SAT_LO) begin
				mixed_s3 <= SAT_LO[S-1:0];
			end else begin
				mixed_s3 <= acc_sh[S-1:0];
			end
		end
	end

	// full pipeline under a stalled output takes no new beat
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !out_ready |-> !in_ready)
		else $error("beat accepted into a full stalled pipeline");

	// a finished ramp leaves no step behind
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_rem_q == '0 |-> ramp_step_q == '0)
		else $error("ramp step left over with no ramp running");

	// committed gain stays within fully wet
	a_mix_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_mix_q <= MIX_FULL)
		else $error("current mix above fully wet");

	// a result only appears from a filled stage 2
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s3) |-> $past(valid_s2))
		else $error("result beat without a stage 2 beat");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for the latency compensated dry/wet mixer
// drives sample beats and apb register writes, predicts every mixed beat in-bench
// depends on lcdwm_pkg and latency_compensated_dry_wet_mixer_top
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdwm_pkg::*;

	localparam int MAX_DELAY    = 1024;
	localparam int CHANNELS     = 8;
	localparam int SAMPLE_BITS  = 24;
	// settle time before a register write: covers the three pipeline stages and the
	// bit-serial ramp divider that a mix_target write may still be running
	localparam int QUIET_CYCLES = 40;
	localparam int DRAIN_LIMIT  = 20000;
	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	// unity gain with 32 fraction bits
	localparam longint UNITY_MIX  = 64'sd1 <<< 32;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CH_W-1:0]     channel;
	sample_t             dry_sample;
	sample_t             wet_sample;
	logic                out_valid;
	logic                out_ready;
	sample_t             mixed_sample;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	latency_compensated_dry_wet_mixer_top #(
		.MAX_DELAY   (MAX_DELAY),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.dry_sample   (dry_sample),
		.wet_sample   (wet_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_sample (mixed_sample),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// ------------------------------------------------------------------
	// mixer shadow: register copies plus the ring, write position and ramp
	// ------------------------------------------------------------------
	sample_t           dry_ring [CHANNELS*MAX_DELAY];
	int                ring_wr;
	longint            cur_mix;      // 32 fraction bits
	longint            mix_step;     // signed step per frame
	int unsigned       ramp_left;    // frames left in the ramp
	logic [LAT_W-1:0]  sh_latency;
	logic [MIXT_W-1:0] sh_target;
	logic [RLEN_W-1:0] sh_ramp_len;
	logic [NCH_W-1:0]  sh_nch;

	// expected mixed beats, oldest first
	sample_t mixed_expect_q [$];
	sample_t want_mix;

	int err_count;
	int beats_sent;
	int beats_checked;
	int ramp_starts;
	int reg_writes;

	// knobs shared by the sender and the receiver processes
	bit tx_idle_on;
	bit rx_idle_on;
	int hold_req;

	// 100 MHz clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void snap_mix();
		cur_mix   = longint'(sh_target) <<< 16;
		mix_step  = 0;
		ramp_left = 0;
	endfunction

	function automatic void shadow_reset();
		foreach (dry_ring[i])
			dry_ring[i] = '0;
		ring_wr     = 0;
		sh_latency  = '0;
		sh_target   = FULL_MIX;
		sh_ramp_len = RST_RAMP_LENGTH;
		sh_nch      = RST_NUM_CH;
		snap_mix();
	endfunction

	// channel count as the block uses it: zero acts as one, too many is clamped
	function automatic int frame_channels();
		if (sh_nch == 0)
			return 1;
		if (sh_nch > CHANNELS)
			return CHANNELS;
		return int'(sh_nch);
	endfunction

	// register write as seen by the block
	function automatic void shadow_reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
		logic [MIXT_W-1:0] tgt;
		longint diff;
		longint mag;
		case (idx)
			REG_LATENCY: begin
				// ring contents stay, stale dry beats are expected
				sh_latency = val[LAT_W-1:0];
			end
			REG_MIX_TARGET: begin
				tgt = val[MIXT_W-1:0];
				if (tgt > FULL_MIX)
					tgt = FULL_MIX;
				// rewriting the same target leaves any ramp running
				if (tgt != sh_target) begin
					sh_target = tgt;
					if (sh_ramp_len == 0) begin
						snap_mix();
					end else begin
						diff      = (longint'(tgt) <<< 16) - cur_mix;
						mag       = (diff < 0 ? -diff : diff) / longint'(sh_ramp_len);
						mix_step  = (diff < 0) ? -mag : mag;
						ramp_left = sh_ramp_len;
						ramp_starts++;
					end
				end
			end
			REG_RAMP_LENGTH: begin
				// a length write ends any ramp at the target
				sh_ramp_len = val[RLEN_W-1:0];
				snap_mix();
			end
			REG_NUM_CHANNELS: begin
				sh_nch = val[NCH_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// one accepted sample beat: ring write and read, crossfade, frame advance
	function automatic sample_t crossfade_beat(logic [CH_W-1:0] ch, sample_t dry, sample_t wet);
		int     cnt;
		int     base;
		int     rd;
		longint mix;
		longint gain;
		longint acc;
		longint res;
		sample_t dly;
		cnt  = frame_channels();
		base = (int'(ch) % CHANNELS) * MAX_DELAY;
		rd   = (ring_wr + MAX_DELAY - int'(sh_latency) % MAX_DELAY) % MAX_DELAY;
		// written first, so latency zero reads back the same beat
		dry_ring[base + ring_wr] = dry;
		dly = dry_ring[base + rd];

		if (ramp_left > 1)
			mix = cur_mix + mix_step;
		else if (ramp_left == 1)
			mix = longint'(sh_target) <<< 16;   // last ramp frame lands on the target
		else
			mix = cur_mix;
		if (mix < 0)
			mix = 0;
		if (mix > UNITY_MIX)
			mix = UNITY_MIX;

		gain = (mix + 32768) >>> 16;
		acc  = longint'(wet) * gain + longint'(dly) * (65536 - gain) + 32768;
		res  = acc >>> 16;   // floor division
		if (res > SAMPLE_MAX)
			res = SAMPLE_MAX;
		if (res < SAMPLE_MIN)
			res = SAMPLE_MIN;

		// frame advance only on the last channel of the frame
		if (int'(ch) == cnt - 1) begin
			cur_mix = mix;
			if (ramp_left > 0) begin
				ramp_left--;
				if (ramp_left == 0)
					mix_step = 0;
			end
			ring_wr = (ring_wr + 1) % MAX_DELAY;
		end
		return res[SAMPLE_BITS-1:0];
	endfunction

	// full scale, near zero or anything
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'(SAMPLE_MAX);
			1: return sample_t'(SAMPLE_MIN);
			2: return sample_t'(int'($urandom_range(0, 64)) - 32);
			default: return sample_t'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------
	// sender side: one sample beat, then maybe an idle burst
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [CH_W-1:0] ch, input sample_t dry, input sample_t wet);
		@(negedge clk);
		in_valid   <= 1'b1;
		channel    <= ch;
		dry_sample <= dry;
		wet_sample <= wet;
		do
			@(posedge clk);
		while (!in_ready);
		mixed_expect_q.push_back(crossfade_beat(ch, dry, wet));
		beats_sent++;
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 18)) @(negedge clk);
		end
	endtask

	// mostly whole frames in channel order, some stray channels and cut frames
	task automatic send_frames(input int n_beats);
		int start;
		int cnt;
		int stop_at;
		int c;
		start = beats_sent;
		cnt   = frame_channels();
		while (beats_sent - start < n_beats) begin
			case ($urandom_range(0, 11))
				0: begin
					send_beat(CH_W'($urandom_range(0, CHANNELS - 1)), rand_sample(),
						rand_sample());
				end
				1: begin
					// frame cut short, the next one starts over at channel zero
					stop_at = $urandom_range(0, cnt - 1);
					for (c = 0; c < stop_at; c++)
						send_beat(CH_W'(c), rand_sample(), rand_sample());
				end
				default: begin
					for (c = 0; c < cnt; c++)
						send_beat(CH_W'(c), rand_sample(), rand_sample());
				end
			endcase
		end
	endtask

	// stop offering beats and wait until every mixed beat is back
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (mixed_expect_q.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		wait_quiet();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		shadow_reg_write(idx, val);
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// receiver side: random stall bursts, or one long hold when asked
	// ------------------------------------------------------------------
	always begin
		@(negedge clk);
		if (hold_req > 0) begin
			out_ready <= 1'b0;
			repeat (hold_req) @(negedge clk);
			hold_req = 0;
			out_ready <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker: every accepted mixed beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (mixed_expect_q.size() == 0) begin
				$error("mixed_sample beat with nothing expected: actual %0d", mixed_sample);
				err_count++;
			end else begin
				want_mix = mixed_expect_q.pop_front();
				beats_checked++;
				if (mixed_sample !== want_mix) begin
					$error("mixed_sample mismatch: expected %0d, actual %0d",
						want_mix, mixed_sample);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// after reset: no delay, fully wet, two channels, so the wet beat comes out
	task automatic test_reset_defaults();
		send_beat(3'd0, sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
		send_beat(3'd1, sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
		send_beat(3'd0, sample_t'(0), sample_t'(-1));
		send_beat(3'd1, sample_t'(-1), sample_t'(0));
	endtask

	// zero ramp length snaps: fully dry straight pass, half mix, clamped target,
	// and a rewrite of the same target
	task automatic test_mix_snap();
		reg_write(REG_RAMP_LENGTH, 32'd0);
		reg_write(REG_MIX_TARGET, 32'd0);
		send_beat(3'd0, sample_t'(SAMPLE_MAX), sample_t'(5));
		send_beat(3'd1, sample_t'(SAMPLE_MIN), sample_t'(-7));
		reg_write(REG_MIX_TARGET, 32'd32768);
		send_beat(3'd0, sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
		send_beat(3'd1, sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN));
		reg_write(REG_MIX_TARGET, 32'h1_FFFF);
		reg_write(REG_MIX_TARGET, 32'(FULL_MIX));
		send_beat(3'd0, sample_t'(1), sample_t'(SAMPLE_MAX));
	endtask

	// three-frame ramp landing on the target, a no-op rewrite, then a ramp cut
	// short by a ramp length write
	task automatic test_ramp_landing();
		int i;
		reg_write(REG_NUM_CHANNELS, 32'd1);
		reg_write(REG_RAMP_LENGTH, 32'd3);
		reg_write(REG_MIX_TARGET, 32'd0);
		for (i = 0; i < 4; i++)
			send_beat(3'd0, sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
		reg_write(REG_MIX_TARGET, 32'd0);
		reg_write(REG_MIX_TARGET, 32'(FULL_MIX));
		send_beat(3'd0, sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
		reg_write(REG_RAMP_LENGTH, 32'd2);
		send_beat(3'd0, sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
	endtask

	// one-frame dry delay exposes when the frame advances: zero count, count above
	// the channel total, and a channel beyond the count
	task automatic test_channel_count();
		reg_write(REG_LATENCY, 32'd1);
		reg_write(REG_RAMP_LENGTH, 32'd0);
		reg_write(REG_MIX_TARGET, 32'd0);
		reg_write(REG_NUM_CHANNELS, 32'd0);
		send_beat(3'd0, sample_t'(100), rand_sample());
		send_beat(3'd0, sample_t'(200), rand_sample());
		reg_write(REG_NUM_CHANNELS, 32'd15);
		send_beat(3'd7, sample_t'(300), rand_sample());
		send_beat(3'd7, sample_t'(400), rand_sample());
		reg_write(REG_NUM_CHANNELS, 32'd2);
		send_beat(3'd5, sample_t'(500), rand_sample());
		send_beat(3'd1, sample_t'(600), rand_sample());
		send_beat(3'd0, sample_t'(700), rand_sample());
	endtask

	// random settings per phase, with a retarget halfway so ramps start mid-ramp
	task automatic test_random_settings();
		int phase;
		logic [APB_DW-1:0] lat_v;
		logic [APB_DW-1:0] ramp_v;
		logic [APB_DW-1:0] tgt_v;
		logic [APB_DW-1:0] nch_v;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					lat_v = 32'd1023; ramp_v = 32'd65535; tgt_v = 32'd0; nch_v = 32'd8;
				end
				1: begin
					lat_v = 32'd0; ramp_v = 32'd0; tgt_v = 32'(FULL_MIX); nch_v = 32'd1;
				end
				default: begin
					case ($urandom_range(0, 4))
						0: lat_v = 32'd0;
						1: lat_v = 32'd1023;
						2: lat_v = 32'd1;
						default: lat_v = $urandom_range(2, 40);
					endcase
					case ($urandom_range(0, 5))
						0: ramp_v = 32'd0;
						1: ramp_v = 32'd65535;
						2: ramp_v = 32'd960;
						default: ramp_v = $urandom_range(1, 12);
					endcase
					case ($urandom_range(0, 5))
						0: tgt_v = 32'd0;
						1: tgt_v = 32'(FULL_MIX);
						2: tgt_v = $urandom_range(65537, 131071);
						default: tgt_v = $urandom_range(0, 65536);
					endcase
					case ($urandom_range(0, 7))
						0: nch_v = 32'd0;
						1: nch_v = $urandom_range(9, 15);
						default: nch_v = $urandom_range(1, 8);
					endcase
				end
			endcase
			reg_write(REG_RAMP_LENGTH, ramp_v);
			reg_write(REG_MIX_TARGET, tgt_v);
			reg_write(REG_LATENCY, lat_v);
			reg_write(REG_NUM_CHANNELS, nch_v);
			send_frames(50);
			reg_write(REG_MIX_TARGET, $urandom_range(0, 131071));
			send_frames(50);
		end
	endtask

	// receiver holds off while the sender keeps offering beats back to back
	task automatic test_output_backpressure();
		reg_write(REG_NUM_CHANNELS, 32'd4);
		reg_write(REG_RAMP_LENGTH, 32'd6);
		reg_write(REG_MIX_TARGET, $urandom_range(0, 65536));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req   = 200;
		send_frames(40);
		rx_idle_on = 1'b1;
	endtask

	// closing stretch at full rate on both sides
	task automatic test_streaming_tail();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		reg_write(REG_LATENCY, $urandom_range(0, 1023));
		reg_write(REG_NUM_CHANNELS, 32'd8);
		reg_write(REG_RAMP_LENGTH, 32'd4);
		reg_write(REG_MIX_TARGET, $urandom_range(0, 65536));
		send_frames(100);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int waited;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		channel       = '0;
		dry_sample    = '0;
		wet_sample    = '0;
		out_ready     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		err_count     = 0;
		beats_sent    = 0;
		beats_checked = 0;
		ramp_starts   = 0;
		reg_writes    = 0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		hold_req      = 0;
		shadow_reset();

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// the ring clearing pass keeps in_ready low, the first beat just waits
		test_reset_defaults();
		test_mix_snap();
		test_ramp_landing();
		test_channel_count();
		test_random_settings();
		test_output_backpressure();
		test_streaming_tail();

		// drain what is still in flight, then give the pipeline time to misbehave
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (mixed_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (QUIET_CYCLES) @(negedge clk);
		if (mixed_expect_q.size() != 0) begin
			$error("mixed_sample: %0d expected beats never arrived", mixed_expect_q.size());
			err_count += mixed_expect_q.size();
		end

		$display("covered %0d sample beats, %0d mixed beats compared", beats_sent,
			beats_checked);
		$display("with %0d register writes and %0d mix ramps started", reg_writes,
			ramp_starts);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
